// File: hdl/otg_pkg.sv
// Shared types and constants for the overlapped tile grid.
// Used by otg_front, otg_fifo, otg_back and overlapped_tile_grid.
package otg_pkg;

   localparam int LENGTH_BITS = 24;
   localparam int INDEX_BITS  = 3;
   localparam int COUNT_BITS  = 4;
   localparam int STATUS_BITS = 2;

   localparam int DATA_BITS = 32;
   localparam int ADDR_BITS = 4;
   localparam int REG_BITS  = 2;

   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int FILL_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [REG_BITS-1:0] REG_SHEET_WIDTH  = 2'd0;
   localparam logic [REG_BITS-1:0] REG_SHEET_HEIGHT = 2'd1;
   localparam logic [REG_BITS-1:0] REG_OVERLAP      = 2'd2;

   localparam logic [LENGTH_BITS-1:0] SHEET_WIDTH_RESET  = 24'd9792;
   localparam logic [LENGTH_BITS-1:0] SHEET_HEIGHT_RESET = 24'd12672;
   localparam logic [LENGTH_BITS-1:0] OVERLAP_RESET      = 24'd0;

   localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_UNUSABLE = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_TOO_MANY = 2'd2;

   typedef struct packed {
      logic [LENGTH_BITS-1:0] page_width;
      logic [LENGTH_BITS-1:0] page_height;
   } otg_req_type;

   typedef struct packed {
      logic [LENGTH_BITS-1:0] tile_x;
      logic [LENGTH_BITS-1:0] tile_y;
      logic [LENGTH_BITS-1:0] tile_width;
      logic [LENGTH_BITS-1:0] tile_height;
      logic [INDEX_BITS-1:0]  tile_column;
      logic [INDEX_BITS-1:0]  tile_row;
      logic [COUNT_BITS-1:0]  grid_columns;
      logic [COUNT_BITS-1:0]  grid_rows;
      logic [STATUS_BITS-1:0] status;
      logic                   last;
   } otg_rsp_type;

   typedef struct packed {
      logic [LENGTH_BITS-1:0] sheet_width;
      logic [LENGTH_BITS-1:0] sheet_height;
      logic [LENGTH_BITS-1:0] overlap_length;
   } otg_cfg_type;

   // One classified page, handed from the front to the back.
   typedef struct packed {
      logic [LENGTH_BITS-1:0] page_width;
      logic [LENGTH_BITS-1:0] page_height;
      logic [LENGTH_BITS-1:0] sheet_width;
      logic [LENGTH_BITS-1:0] sheet_height;
      logic [LENGTH_BITS-1:0] step_across;
      logic [LENGTH_BITS-1:0] step_down;
      logic [COUNT_BITS-1:0]  columns;
      logic [COUNT_BITS-1:0]  rows;
      logic [STATUS_BITS-1:0] status;
   } otg_job_type;

endpackage

// File: hdl/otg_front.sv
// Front end: accepts a page word, clamps the overlap and counts tiles per axis.
// Depends on otg_pkg; feeds otg_fifo.
module otg_front
   import otg_pkg::*;
#(
   parameter int MAX_AXIS_TILES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  otg_req_type req_word,
   input  otg_cfg_type cfg,
   output logic        push,
   output otg_job_type push_word,
   input  logic        full
);

   localparam logic [2:0] F_IDLE = 3'd0;
   localparam logic [2:0] F_PREP = 3'd1;
   localparam logic [2:0] F_INIT = 3'd2;
   localparam logic [2:0] F_CALC = 3'd3;
   localparam logic [2:0] F_PUSH = 3'd4;

   localparam logic [COUNT_BITS-1:0] MAX_COUNT = COUNT_BITS'(MAX_AXIS_TILES);

   logic [2:0] state_ff, state_in;

   logic [LENGTH_BITS-1:0] page_w_ff, page_h_ff, sheet_w_ff, sheet_h_ff, ovr_ff;
   logic [LENGTH_BITS-1:0] ovl_ff, ovl_in;
   logic                   err_ff, err_in, fit_x_ff, fit_x_in, fit_y_ff, fit_y_in;
   logic [LENGTH_BITS-1:0] step_x_ff, step_x_in, step_y_ff, step_y_in;
   logic [LENGTH_BITS-1:0] span_x_ff, span_x_in, span_y_ff, span_y_in;
   logic [LENGTH_BITS:0]   acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic [COUNT_BITS-1:0]  k_x_ff, k_x_in, k_y_ff, k_y_in;
   logic                   done_x_ff, done_x_in, done_y_ff, done_y_in;

   logic [LENGTH_BITS-1:0] short_side, half_side;
   logic [LENGTH_BITS:0]   sum_x, sum_y;
   logic [COUNT_BITS-1:0]  kn_x, kn_y;
   logic                   accept;

   assign req_stall = (state_ff != F_IDLE);
   assign accept    = req_valid && !req_stall;

   assign short_side = (sheet_w_ff < sheet_h_ff) ? sheet_w_ff : sheet_h_ff;
   assign half_side  = short_side >> 1;
   assign sum_x      = acc_x_ff + {1'b0, step_x_ff};
   assign sum_y      = acc_y_ff + {1'b0, step_y_ff};
   assign kn_x       = k_x_ff + COUNT_BITS'(1);
   assign kn_y       = k_y_ff + COUNT_BITS'(1);

   always_comb begin
      state_in  = state_ff;
      ovl_in    = ovl_ff;
      err_in    = err_ff;
      fit_x_in  = fit_x_ff;
      fit_y_in  = fit_y_ff;
      step_x_in = step_x_ff;
      step_y_in = step_y_ff;
      span_x_in = span_x_ff;
      span_y_in = span_y_ff;
      acc_x_in  = acc_x_ff;
      acc_y_in  = acc_y_ff;
      k_x_in    = k_x_ff;
      k_y_in    = k_y_ff;
      done_x_in = done_x_ff;
      done_y_in = done_y_ff;
      push      = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) state_in = F_PREP;
         end
         F_PREP: begin
            ovl_in   = (ovr_ff < half_side) ? ovr_ff : half_side;
            err_in   = (page_w_ff == '0) || (page_h_ff == '0) ||
                       (sheet_w_ff == '0) || (sheet_h_ff == '0);
            fit_x_in = (page_w_ff <= sheet_w_ff);
            fit_y_in = (page_h_ff <= sheet_h_ff);
            state_in = err_in ? F_PUSH : F_INIT;
         end
         F_INIT: begin
            step_x_in = sheet_w_ff - ovl_ff;
            step_y_in = sheet_h_ff - ovl_ff;
            span_x_in = page_w_ff - ovl_ff;
            span_y_in = page_h_ff - ovl_ff;
            acc_x_in  = '0;
            acc_y_in  = '0;
            k_x_in    = fit_x_ff ? COUNT_BITS'(1) : '0;
            k_y_in    = fit_y_ff ? COUNT_BITS'(1) : '0;
            done_x_in = fit_x_ff;
            done_y_in = fit_y_ff;
            state_in  = F_CALC;
         end
         F_CALC: begin
            // One step per axis per cycle: the count is the first k with k*step >= span.
            if (!done_x_ff) begin
               acc_x_in  = sum_x;
               k_x_in    = kn_x;
               done_x_in = (sum_x >= {1'b0, span_x_ff}) || (kn_x > MAX_COUNT);
            end
            if (!done_y_ff) begin
               acc_y_in  = sum_y;
               k_y_in    = kn_y;
               done_y_in = (sum_y >= {1'b0, span_y_ff}) || (kn_y > MAX_COUNT);
            end
            if (done_x_ff && done_y_ff) state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!full) begin
               push     = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      push_word              = '0;
      push_word.page_width   = page_w_ff;
      push_word.page_height  = page_h_ff;
      push_word.sheet_width  = sheet_w_ff;
      push_word.sheet_height = sheet_h_ff;
      push_word.step_across  = (k_x_ff > COUNT_BITS'(1)) ? step_x_ff : sheet_w_ff;
      push_word.step_down    = (k_y_ff > COUNT_BITS'(1)) ? step_y_ff : sheet_h_ff;
      push_word.columns      = k_x_ff;
      push_word.rows         = k_y_ff;
      priority if (err_ff) begin
         push_word.status = STATUS_UNUSABLE;
      end else if ((k_x_ff > MAX_COUNT) || (k_y_ff > MAX_COUNT)) begin
         push_word.status = STATUS_TOO_MANY;
      end else begin
         push_word.status = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= F_IDLE;
         done_x_ff <= 1'b0;
         done_y_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         done_x_ff <= done_x_in;
         done_y_ff <= done_y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         page_w_ff  <= req_word.page_width;
         page_h_ff  <= req_word.page_height;
         sheet_w_ff <= cfg.sheet_width;
         sheet_h_ff <= cfg.sheet_height;
         ovr_ff     <= cfg.overlap_length;
      end
      ovl_ff    <= ovl_in;
      err_ff    <= err_in;
      fit_x_ff  <= fit_x_in;
      fit_y_ff  <= fit_y_in;
      step_x_ff <= step_x_in;
      step_y_ff <= step_y_in;
      span_x_ff <= span_x_in;
      span_y_ff <= span_y_in;
      acc_x_ff  <= acc_x_in;
      acc_y_ff  <= acc_y_in;
      k_x_ff    <= k_x_in;
      k_y_ff    <= k_y_in;
   end

endmodule

// File: hdl/otg_fifo.sv
// Short queue of classified pages between the front and the back.
// Depends on otg_pkg.
module otg_fifo
   import otg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  otg_job_type push_word,
   output logic        full,
   input  logic        pop,
   output otg_job_type pop_word,
   output logic        empty
);

   otg_job_type mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FILL_BITS-1:0] fill_ff, fill_in;
   logic                 do_push, do_pop;

   assign full     = (fill_ff == FILL_BITS'(QUEUE_DEPTH));
   assign empty    = (fill_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_word = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                              : wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                              : rd_ptr_ff + PTR_BITS'(1);
      end
      if (do_push && !do_pop) fill_in = fill_ff + FILL_BITS'(1);
      else if (do_pop && !do_push) fill_in = fill_ff - FILL_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_word;
   end

endmodule

// File: hdl/otg_back.sv
// Back end: walks the grid of one classified page and emits one tile word per cycle while rsp is not stalled.
// Depends on otg_pkg; drains otg_fifo.
module otg_back
   import otg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   output logic        pop,
   input  otg_job_type pop_word,
   input  logic        empty,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output otg_rsp_type rsp_word
);

   otg_job_type            job_ff;
   logic                   busy_ff, busy_in;
   logic [INDEX_BITS-1:0]  col_ff, col_in, row_ff, row_in;
   logic [LENGTH_BITS-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic                   out_valid_ff, out_valid_in;
   otg_rsp_type            out_word_ff, out_word_in;

   logic                   emit, col_last, row_last, is_last;
   logic [LENGTH_BITS-1:0] rest_x, rest_y, clip_w, clip_h;

   assign pop  = !busy_ff && !empty;
   assign emit = busy_ff && (!out_valid_ff || !rsp_stall);

   assign col_last = ({1'b0, col_ff} == job_ff.columns - COUNT_BITS'(1));
   assign row_last = ({1'b0, row_ff} == job_ff.rows - COUNT_BITS'(1));
   assign is_last  = (job_ff.status != STATUS_OK) || (col_last && row_last);

   assign rest_x = job_ff.page_width - pos_x_ff;
   assign rest_y = job_ff.page_height - pos_y_ff;
   assign clip_w = (pos_x_ff >= job_ff.page_width) ? '0 :
                   (rest_x < job_ff.sheet_width) ? rest_x : job_ff.sheet_width;
   assign clip_h = (pos_y_ff >= job_ff.page_height) ? '0 :
                   (rest_y < job_ff.sheet_height) ? rest_y : job_ff.sheet_height;

   always_comb begin
      busy_in      = busy_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      if (pop) begin
         busy_in  = 1'b1;
         col_in   = '0;
         row_in   = '0;
         pos_x_in = '0;
         pos_y_in = '0;
      end
      if (!rsp_stall) out_valid_in = 1'b0;
      if (emit) begin
         out_valid_in = 1'b1;
         out_word_in  = '0;
         out_word_in.status = job_ff.status;
         out_word_in.last   = is_last;
         if (job_ff.status == STATUS_OK) begin
            out_word_in.tile_x       = pos_x_ff;
            out_word_in.tile_y       = pos_y_ff;
            out_word_in.tile_width   = clip_w;
            out_word_in.tile_height  = clip_h;
            out_word_in.tile_column  = col_ff;
            out_word_in.tile_row     = row_ff;
            out_word_in.grid_columns = job_ff.columns;
            out_word_in.grid_rows    = job_ff.rows;
         end
         // Advance row-major: step across, wrap to the next row at the end.
         if (col_last) begin
            col_in   = '0;
            pos_x_in = '0;
            row_in   = row_ff + INDEX_BITS'(1);
            pos_y_in = pos_y_ff + job_ff.step_down;
         end else begin
            col_in   = col_ff + INDEX_BITS'(1);
            pos_x_in = pos_x_ff + job_ff.step_across;
         end
         if (is_last) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) job_ff <= pop_word;
      col_ff      <= col_in;
      row_ff      <= row_in;
      pos_x_ff    <= pos_x_in;
      pos_y_ff    <= pos_y_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule

// File: hdl/overlapped_tile_grid.sv
// Top level of the overlapped tile grid: configuration registers and the
// front / queue / back chain. Depends on otg_pkg, otg_front, otg_fifo, otg_back.
//
//   channel | direction | handshake             | word
//   req     | in        | req_valid / req_stall | otg_req_type (page size)
//   rsp     | out       | rsp_valid / rsp_stall | otg_rsp_type (one tile)
//   csr     | in/out    | csr_psel / penable    | 24-bit registers at 4*index
//
// Flow: the front steps a page through F_PREP, F_INIT, F_CALC and F_PUSH, with
//   at most MAX_AXIS_TILES + 1 counting steps per axis in F_CALC (the per-axis
//   count loop sets this), and takes the next page once it has queued this one;
//   an unusable page skips the count and goes from F_PREP straight to F_PUSH.
//   The back loads a page from the queue, then emits columns*rows words, one
//   per cycle while rsp is not stalled; an error page gives a single word.
// The two-entry queue lets the front classify the next page while the back
//   is still emitting tiles; a page rate is set by the slower of the two.
// Reset is synchronous and clears control state and the registers to their
//   defaults. A stall on rsp holds the output word; the back then holds too.

module overlapped_tile_grid
   import otg_pkg::*;
#(
   parameter int MAX_AXIS_TILES = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  otg_req_type          req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output otg_rsp_type          rsp_word,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [ADDR_BITS-1:0] csr_paddr,
   input  logic [DATA_BITS-1:0] csr_pwdata,
   output logic [DATA_BITS-1:0] csr_prdata,
   output logic                 csr_pready
);

   otg_cfg_type         cfg_ff, cfg_in;
   logic                csr_write;
   logic [REG_BITS-1:0] csr_index;

   logic        push, full, pop, empty;
   otg_job_type push_word, pop_word;

   // Configuration port: zero-wait, written in the access phase.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[ADDR_BITS-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_SHEET_WIDTH:  cfg_in.sheet_width    = csr_pwdata[LENGTH_BITS-1:0];
            REG_SHEET_HEIGHT: cfg_in.sheet_height   = csr_pwdata[LENGTH_BITS-1:0];
            REG_OVERLAP:      cfg_in.overlap_length = csr_pwdata[LENGTH_BITS-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_SHEET_WIDTH:  csr_prdata = DATA_BITS'(cfg_ff.sheet_width);
         REG_SHEET_HEIGHT: csr_prdata = DATA_BITS'(cfg_ff.sheet_height);
         REG_OVERLAP:      csr_prdata = DATA_BITS'(cfg_ff.overlap_length);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sheet_width    <= SHEET_WIDTH_RESET;
         cfg_ff.sheet_height   <= SHEET_HEIGHT_RESET;
         cfg_ff.overlap_length <= OVERLAP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: take a page word, clamp overlap, count tiles per axis.
   otg_front #(
      .MAX_AXIS_TILES(MAX_AXIS_TILES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .cfg       (cfg_ff),
      .push      (push),
      .push_word (push_word),
      .full      (full)
   );

   // Queue: decouple classification from tile emission.
   otg_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .full      (full),
      .pop       (pop),
      .pop_word  (pop_word),
      .empty     (empty)
   );

   // Back: walk the grid row-major, one word per cycle into the output register while rsp is not stalled.
   otg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop       (pop),
      .pop_word  (pop_word),
      .empty     (empty),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // An error word always closes its page.
   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status != STATUS_OK) |-> rsp_word.last)
      else $error("error word without last mark");

   // Error words carry no grid.
   a_error_no_grid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status != STATUS_OK) |->
         (rsp_word.grid_columns == '0) && (rsp_word.grid_rows == '0))
      else $error("error word with grid counts");

   // Tile indices stay inside the announced grid.
   a_index_in_grid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status == STATUS_OK) |->
         ({1'b0, rsp_word.tile_column} < rsp_word.grid_columns) &&
         ({1'b0, rsp_word.tile_row} < rsp_word.grid_rows))
      else $error("tile index outside grid");

   // An ok grid never exceeds the axis limit.
   a_grid_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status == STATUS_OK) |->
         (rsp_word.grid_columns <= COUNT_BITS'(MAX_AXIS_TILES)) &&
         (rsp_word.grid_rows <= COUNT_BITS'(MAX_AXIS_TILES)))
      else $error("grid larger than axis limit");

endmodule
